[hw/rtl/bgpe_pkg.sv]
`timescale 1ns / 1ps

package bgpe_pkg;

  localparam int GLYPH_SLOTS   = 96;
  localparam int BITMAP_BYTES  = 4096;
  localparam int MAX_ROWS      = 16;
  localparam int PIX_PER_RES   = 4;

  localparam int MAX_CELL      = 16;
  localparam int MAX_GLYPH_PIX = 240;
  localparam int MAX_RESULTS   = 64;
  localparam int MAX_PIX       = MAX_RESULTS * PIX_PER_RES;

  localparam int BYTE_W = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int WID_AW = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
  localparam int OFS_AW = $clog2(GLYPH_SLOTS + 1);
  localparam int N_W    = $clog2(MAX_PIX + 1);
  localparam int CNT_W  = $clog2(MAX_GLYPH_PIX + 1);
  localparam int QDEPTH = 2;

  localparam logic [1:0] CMD_LOAD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_LOAD_GLYPH = 2'd1;
  localparam logic [1:0] CMD_DRAW       = 2'd2;

  localparam logic [2:0] CFG_FIRST_CODE = 3'd0;
  localparam logic [2:0] CFG_LAST_CODE  = 3'd1;
  localparam logic [2:0] CFG_FONT_ROWS  = 3'd2;
  localparam logic [2:0] CFG_CELL_WIDTH = 3'd3;
  localparam logic [2:0] CFG_MONOSPACE  = 3'd4;
  localparam logic [2:0] CFG_FG_COLOR   = 3'd5;
  localparam logic [2:0] CFG_BG_COLOR   = 3'd6;

  typedef enum logic [1:0] {
    OP_LOAD_BYTE,
    OP_LOAD_GLYPH,
    OP_DRAW,
    OP_BLANK
  } op_e;

  typedef struct packed {
    logic [7:0]  first_code;
    logic [7:0]  last_code;
    logic [4:0]  font_rows;
    logic [4:0]  cell_width;
    logic        monospace_mode;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  char_code;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [11:0] load_index;
    logic [7:0]  load_byte;
    logic [3:0]  load_width;
    logic [14:0] load_offset;
  } in_t;

  typedef struct packed {
    op_e         op;
    logic [7:0]  idx;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [11:0] load_index;
    logic [7:0]  load_byte;
    logic [3:0]  load_width;
    logic [14:0] load_offset;
  } q_entry_t;

  typedef struct packed {
    logic [15:0] win_x_start;
    logic [15:0] win_x_end;
    logic [15:0] win_y_start;
    logic [15:0] win_y_end;
    logic [15:0] pixel_a;
    logic [15:0] pixel_b;
    logic [15:0] pixel_c;
    logic [15:0] pixel_d;
    logic [2:0]  pixel_count;
    logic [4:0]  advance;
    logic        last_flag;
  } res_t;

endpackage

[hw/rtl/bgpe_front.sv]
`timescale 1ns / 1ps

module bgpe_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bgpe_pkg::in_t      in_i,
  input  bgpe_pkg::cfg_t     cfg_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output bgpe_pkg::q_entry_t push_data_o
);
  import bgpe_pkg::*;

  logic       fe_valid_q;
  q_entry_t   fe_q;
  q_entry_t   fe_d;
  logic [7:0] idx;
  logic       printable;
  logic       keep;

  assign idx       = in_i.char_code - cfg_i.first_code;
  assign printable = (in_i.char_code >= cfg_i.first_code) &&
                     (in_i.char_code <= cfg_i.last_code) &&
                     (32'(idx) < GLYPH_SLOTS);

  always_comb begin
    fe_d.idx         = idx;
    fe_d.pos_x       = in_i.pos_x;
    fe_d.pos_y       = in_i.pos_y;
    fe_d.load_index  = in_i.load_index;
    fe_d.load_byte   = in_i.load_byte;
    fe_d.load_width  = in_i.load_width;
    fe_d.load_offset = in_i.load_offset;
    keep             = 1'b1;
    unique case (in_i.cmd)
      CMD_LOAD_BYTE:  fe_d.op = OP_LOAD_BYTE;
      CMD_LOAD_GLYPH: fe_d.op = OP_LOAD_GLYPH;
      CMD_DRAW:       fe_d.op = printable ? OP_DRAW : OP_BLANK;
      default: begin
        // reserved command: swallowed, no result
        fe_d.op = OP_BLANK;
        keep    = 1'b0;
      end
    endcase
  end

  assign in_ready_o   = !fe_valid_q || push_ready_i;
  assign push_valid_o = fe_valid_q;
  assign push_data_o  = fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      fe_valid_q <= in_valid_i && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      fe_q <= fe_d;
    end
  end

endmodule

[hw/rtl/bgpe_queue.sv]
`timescale 1ns / 1ps

module bgpe_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  bgpe_pkg::q_entry_t push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output bgpe_pkg::q_entry_t pop_data_o
);
  import bgpe_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_QW = $clog2(QDEPTH + 1);

  q_entry_t            mem_q [QDEPTH];
  logic [PTR_W-1:0]    wr_ptr_q;
  logic [PTR_W-1:0]    rd_ptr_q;
  logic [CNT_QW-1:0]   count_q;
  logic                do_push;
  logic                do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign push_ready_o = (count_q != CNT_QW'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop) count_q <= count_q + CNT_QW'(1);
      else if (do_pop && !do_push) count_q <= count_q - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

[hw/rtl/bgpe_back.sv]
`timescale 1ns / 1ps

module bgpe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bgpe_pkg::cfg_t     cfg_i,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  bgpe_pkg::q_entry_t pop_data_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output bgpe_pkg::res_t     res_o
);
  import bgpe_pkg::*;

  localparam int BODY_W = N_W + 1;
  localparam int RED_W  = 12;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_CALC2,
    S_MOD,
    S_PIX,
    S_BLANK
  } state_e;

  state_e state_q;

  // stores
  logic [7:0]  font_mem [BITMAP_BYTES];
  logic [3:0]  wid_mem  [GLYPH_SLOTS];
  logic [14:0] ofs_mem  [GLYPH_SLOTS + 1];

  logic [7:0]  font_lo_q, font_hi_q;
  logic [3:0]  wid_rd_q;
  logic [14:0] ofs0_rd_q, ofs1_rd_q;

  logic              font_we, wid_we, ofs_we;
  logic [BYTE_W-1:0] rd_lo_a, rd_hi_a;
  logic [OFS_AW-1:0] ofs_a, ofs_b;

  // draw context
  logic [15:0]       x_q, y_q, xend_q, yend_q;
  logic [4:0]        rows_q, cw_q, adv_q;
  logic              mono_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [N_W-1:0]    pad_q, total_q, n_q, p0_q;
  logic [BODY_W-1:0] body_q;
  logic [RED_W-1:0]  red_q;
  logic [2:0]        sub_init_q;
  logic [BYTE_W-1:0] ptr_q, ptr_d;
  logic [2:0]        sub_q, sub_d;

  logic              res_valid_q;
  res_t              res_q;
  logic              out_free;

  logic [4:0]        rows_sat, cw_sat;
  logic [15:0]       ofs_diff;
  logic [CNT_W-1:0]  cnt_d;
  logic [4:0]        diffw;
  logic [9:0]        pad_prod, total_prod;
  logic [BODY_W-1:0] body_d, nn;
  logic [N_W-1:0]    n_d;

  logic [15:0]       pix [4];
  logic [2:0]        pix_cnt;
  logic [2:0]        glyph_tot;
  logic              pix_last;
  logic [15:0]       window;

  function automatic logic [BYTE_W-1:0] byte_inc(input logic [BYTE_W-1:0] b);
    return (b == BYTE_W'(BITMAP_BYTES - 1)) ? '0 : b + BYTE_W'(1);
  endfunction

  assign out_free    = !res_valid_q || res_ready_i;
  assign pop_ready_o = (state_q == S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign rows_sat = (32'(cfg_i.font_rows) > MAX_ROWS) ? 5'(MAX_ROWS) : cfg_i.font_rows;
  assign cw_sat   = (32'(cfg_i.cell_width) > MAX_CELL) ? 5'(MAX_CELL) : cfg_i.cell_width;

  // ---------------- memories ----------------
  assign font_we = pop_valid_i && pop_ready_o && (pop_data_i.op == OP_LOAD_BYTE) &&
                   (32'(pop_data_i.load_index) < BITMAP_BYTES);
  assign wid_we  = pop_valid_i && pop_ready_o && (pop_data_i.op == OP_LOAD_GLYPH) &&
                   (32'(pop_data_i.load_index) < GLYPH_SLOTS);
  assign ofs_we  = pop_valid_i && pop_ready_o && (pop_data_i.op == OP_LOAD_GLYPH) &&
                   (32'(pop_data_i.load_index) <= GLYPH_SLOTS);

  assign rd_lo_a = ptr_d;
  assign rd_hi_a = byte_inc(ptr_d);
  assign ofs_a   = OFS_AW'(pop_data_i.idx);
  assign ofs_b   = ofs_a + OFS_AW'(1);

  always_ff @(posedge clk_i) begin
    if (font_we) font_mem[BYTE_W'(pop_data_i.load_index)] <= pop_data_i.load_byte;
    font_lo_q <= font_mem[rd_lo_a];
    font_hi_q <= font_mem[rd_hi_a];
  end

  always_ff @(posedge clk_i) begin
    if (wid_we) wid_mem[WID_AW'(pop_data_i.load_index)] <= pop_data_i.load_width;
    if (ofs_we) ofs_mem[OFS_AW'(pop_data_i.load_index)] <= pop_data_i.load_offset;
    wid_rd_q  <= wid_mem[WID_AW'(pop_data_i.idx)];
    ofs0_rd_q <= ofs_mem[ofs_a];
    ofs1_rd_q <= ofs_mem[ofs_b];
  end

  // ---------------- setup arithmetic ----------------
  always_comb begin
    ofs_diff = {1'b0, ofs1_rd_q} - {1'b0, ofs0_rd_q};
    if (ofs1_rd_q <= ofs0_rd_q) cnt_d = '0;
    else if (32'(ofs_diff) > MAX_GLYPH_PIX) cnt_d = CNT_W'(MAX_GLYPH_PIX);
    else cnt_d = CNT_W'(ofs_diff);
    diffw      = (cw_q > 5'(wid_rd_q)) ? ((cw_q - 5'(wid_rd_q)) >> 1) : 5'd0;
    pad_prod   = 10'(rows_q * diffw);
    total_prod = 10'(rows_q * cw_q);
  end

  always_comb begin
    body_d = BODY_W'(pad_q) + BODY_W'(cnt_q);
    if (mono_q) nn = (body_d > BODY_W'(total_q)) ? body_d : BODY_W'(total_q);
    else nn = BODY_W'(cnt_q) + BODY_W'(rows_q);
    n_d = (32'(nn) > MAX_PIX) ? N_W'(MAX_PIX) : N_W'(nn);
  end

  // ---------------- pixel group ----------------
  assign window = {font_hi_q, font_lo_q};

  always_comb begin
    logic [N_W:0] p;
    logic [3:0]   sel;
    logic         vld;
    logic         gly;
    pix_cnt   = '0;
    glyph_tot = '0;
    for (int j = 0; j < 4; j++) begin
      p      = (N_W + 1)'(p0_q) + (N_W + 1)'(j);
      vld    = (j < PIX_PER_RES) && (p < (N_W + 1)'(n_q));
      gly    = vld && (p >= (N_W + 1)'(pad_q)) && ((N_W + 1)'(p) < body_q);
      sel    = {1'b0, sub_q} + {1'b0, glyph_tot};
      pix[j] = '0;
      if (vld) begin
        pix[j]  = (gly && window[sel]) ? cfg_i.fg_color : cfg_i.bg_color;
        pix_cnt = pix_cnt + 3'd1;
      end
      if (gly) glyph_tot = glyph_tot + 3'd1;
    end
    pix_last = ((N_W + 1)'(p0_q) + (N_W + 1)'(PIX_PER_RES)) >= (N_W + 1)'(n_q);
  end

  // bit pointer into the font memory; reads are issued from the next value
  always_comb begin
    logic [3:0] s;
    s     = {1'b0, sub_q} + {1'b0, glyph_tot};
    ptr_d = ptr_q;
    sub_d = sub_q;
    if (state_q == S_MOD && 32'(red_q) < BITMAP_BYTES) begin
      ptr_d = BYTE_W'(red_q);
      sub_d = sub_init_q;
    end else if (state_q == S_PIX && out_free) begin
      sub_d = s[2:0];
      if (s[3]) ptr_d = byte_inc(ptr_q);
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      x_q <= '0; y_q <= '0; xend_q <= '0; yend_q <= '0;
      rows_q <= '0; cw_q <= '0; adv_q <= '0; mono_q <= 1'b0;
      cnt_q <= '0; pad_q <= '0; total_q <= '0; n_q <= '0; p0_q <= '0;
      body_q <= '0; red_q <= '0; sub_init_q <= '0;
      ptr_q <= '0; sub_q <= '0;
    end else begin
      ptr_q <= ptr_d;
      sub_q <= sub_d;
      if (res_ready_i) res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (pop_valid_i) begin
            x_q    <= pop_data_i.pos_x;
            y_q    <= pop_data_i.pos_y;
            rows_q <= rows_sat;
            cw_q   <= cw_sat;
            mono_q <= cfg_i.monospace_mode;
            if (pop_data_i.op == OP_DRAW) state_q <= S_CALC;
            else if (pop_data_i.op == OP_BLANK) state_q <= S_BLANK;
          end
        end
        S_CALC: begin
          cnt_q      <= cnt_d;
          pad_q      <= mono_q ? N_W'(pad_prod) : '0;
          total_q    <= N_W'(total_prod);
          red_q      <= RED_W'(ofs0_rd_q >> 3);
          sub_init_q <= ofs0_rd_q[2:0];
          yend_q     <= y_q + 16'(rows_q) + 16'hFFFF;
          if (mono_q) begin
            xend_q <= x_q + 16'(cw_q) + 16'hFFFF;
            adv_q  <= cw_q;
          end else begin
            xend_q <= x_q + 16'(wid_rd_q);
            adv_q  <= 5'(wid_rd_q) + 5'd1;
          end
          state_q <= S_CALC2;
        end
        S_CALC2: begin
          body_q  <= body_d;
          n_q     <= n_d;
          p0_q    <= '0;
          state_q <= S_MOD;
        end
        S_MOD: begin
          // reduce the start byte address modulo the bitmap size
          if (32'(red_q) >= BITMAP_BYTES) red_q <= red_q - RED_W'(BITMAP_BYTES);
          else state_q <= S_PIX;
        end
        S_PIX: begin
          if (out_free) begin
            res_valid_q       <= 1'b1;
            res_q.win_x_start <= x_q;
            res_q.win_x_end   <= xend_q;
            res_q.win_y_start <= y_q;
            res_q.win_y_end   <= yend_q;
            res_q.pixel_a     <= pix[0];
            res_q.pixel_b     <= pix[1];
            res_q.pixel_c     <= pix[2];
            res_q.pixel_d     <= pix[3];
            res_q.pixel_count <= pix_cnt;
            res_q.advance     <= adv_q;
            res_q.last_flag   <= pix_last;
            p0_q              <= N_W'((N_W + 1)'(p0_q) + (N_W + 1)'(PIX_PER_RES));
            if (pix_last) state_q <= S_IDLE;
          end
        end
        S_BLANK: begin
          if (out_free) begin
            res_valid_q     <= 1'b1;
            res_q           <= '0;
            res_q.last_flag <= 1'b1;
            state_q         <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // only the final result of a draw may be partly filled
  a_full_unless_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.last_flag |-> res_q.pixel_count == 3'(PIX_PER_RES))
    else $error("non-final result not full");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.pixel_count == 3'd0 |-> res_q.last_flag)
    else $error("empty result not marked last");

  a_p0_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PIX && out_free && !pix_last |=>
      p0_q == $past(p0_q) + N_W'(PIX_PER_RES))
    else $error("pixel index did not advance by one group");

endmodule

[hw/rtl/bitmap_glyph_pixel_expander_unit.sv]
// Load items: one per cycle while the sequencer is idle; stored via the front register and queue.
// Draw items: the first result follows 3 setup steps in the back sequencer (S_CALC,
// S_CALC2, S_MOD, plus one step per start-byte wrap), then one result per cycle while
// the output is ready, from the font memory's two read ports, up to 64 results per draw.
// A short queue between classifier and sequencer absorbs items during a draw.
// Reset: config registers take their defaults; font and glyph stores are undefined until written.
`timescale 1ns / 1ps

module bitmap_glyph_pixel_expander_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // char_code, pos_x, pos_y, load_index, load_byte, load_width, load_offset
  input  logic [79:0]  s_axis_tdata_i,
  // cmd
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // win_x_start, win_x_end, win_y_start, win_y_end, pixel_a, pixel_b,
  // pixel_c, pixel_d, pixel_count, advance
  output logic [135:0] m_axis_tdata_o,
  // last_flag
  output logic         m_axis_tlast_o,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [15:0]  cfg_wdata_i
);
  import bgpe_pkg::*;

  cfg_t     cfg_q;
  in_t      in_item;
  logic     push_valid, push_ready, pop_valid, pop_ready;
  q_entry_t push_data, pop_data;
  res_t     res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_code     <= 8'd32;
      cfg_q.last_code      <= 8'd127;
      cfg_q.font_rows      <= 5'd11;
      cfg_q.cell_width     <= 5'd8;
      cfg_q.monospace_mode <= 1'b0;
      cfg_q.fg_color       <= 16'hFFFF;
      cfg_q.bg_color       <= 16'h0000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIRST_CODE: cfg_q.first_code     <= cfg_wdata_i[7:0];
        CFG_LAST_CODE:  cfg_q.last_code      <= cfg_wdata_i[7:0];
        CFG_FONT_ROWS:  cfg_q.font_rows      <= cfg_wdata_i[4:0];
        CFG_CELL_WIDTH: cfg_q.cell_width     <= cfg_wdata_i[4:0];
        CFG_MONOSPACE:  cfg_q.monospace_mode <= cfg_wdata_i[0];
        CFG_FG_COLOR:   cfg_q.fg_color       <= cfg_wdata_i;
        CFG_BG_COLOR:   cfg_q.bg_color       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_item.cmd         = s_axis_tuser_i;
  assign in_item.char_code   = s_axis_tdata_i[7:0];
  assign in_item.pos_x       = s_axis_tdata_i[23:8];
  assign in_item.pos_y       = s_axis_tdata_i[39:24];
  assign in_item.load_index  = s_axis_tdata_i[51:40];
  assign in_item.load_byte   = s_axis_tdata_i[59:52];
  assign in_item.load_width  = s_axis_tdata_i[63:60];
  assign in_item.load_offset = s_axis_tdata_i[78:64];

  bgpe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_i         (in_item),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  bgpe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  bgpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {res.advance, res.pixel_count, res.pixel_d, res.pixel_c,
                           res.pixel_b, res.pixel_a, res.win_y_end, res.win_y_start,
                           res.win_x_end, res.win_x_start};
  assign m_axis_tlast_o = res.last_flag;

endmodule
